@@ rtl/look_at_rotation_basis_macros.svh @@
// Assertion macros for the look-at rotation basis block.
// Depends on nothing; included by the top level.
`ifndef LOOK_AT_ROTATION_BASIS_MACROS_SVH
`define LOOK_AT_ROTATION_BASIS_MACROS_SVH

// Same-cycle implication under synchronous active-low reset.
`define LAB_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication under synchronous active-low reset.
`define LAB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ rtl/lab_pkg.sv @@
// Types and constants of the look-at rotation basis block.
// Depends on nothing; used by lab_norm and look_at_rotation_basis.
package lab_pkg;

    localparam int IN_W   = 32;
    localparam int WIDE_W = 33;
    localparam int UNIT_W = 16;

    typedef logic [WIDE_W-1:0] t_wide;
    typedef t_wide [2:0]       t_wvec;
    typedef logic [UNIT_W-1:0] t_unit;
    typedef t_unit [2:0]       t_uvec;

    typedef struct packed {
        logic signed [IN_W-1:0] pos_x;
        logic signed [IN_W-1:0] pos_y;
        logic signed [IN_W-1:0] pos_z;
        logic signed [IN_W-1:0] look_x;
        logic signed [IN_W-1:0] look_y;
        logic signed [IN_W-1:0] look_z;
        logic signed [IN_W-1:0] up_x;
        logic signed [IN_W-1:0] up_y;
        logic signed [IN_W-1:0] up_z;
    } t_req;

    typedef struct packed {
        logic signed [UNIT_W-1:0] right_x;
        logic signed [UNIT_W-1:0] right_y;
        logic signed [UNIT_W-1:0] right_z;
        logic signed [UNIT_W-1:0] upaxis_x;
        logic signed [UNIT_W-1:0] upaxis_y;
        logic signed [UNIT_W-1:0] upaxis_z;
        logic signed [UNIT_W-1:0] fwd_x;
        logic signed [UNIT_W-1:0] fwd_y;
        logic signed [UNIT_W-1:0] fwd_z;
        logic                     degenerate;
    } t_res;

endpackage

@@ rtl/lab_norm.sv @@
// Pipelined vector normalizer: range shift, squares, bit-serial square root
// and restoring division, one stage per step. Depends on lab_pkg.
module lab_norm #(
    parameter int SW = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_vld,
    input  lab_pkg::t_wvec   i_vec,
    input  logic             i_deg,
    input  logic [SW-1:0]    i_side,
    output logic             o_vld,
    output lab_pkg::t_uvec   o_unit,
    output logic             o_deg,
    output logic [SW-1:0]    o_side
);
    import lab_pkg::*;

    localparam int MW        = WIDE_W;
    localparam int LW        = 6;
    localparam int NW        = 30;
    localparam int SQW       = 2 * NW;
    localparam int RTW       = 63;
    localparam int ISQ_STEPS = 31;
    localparam int ISQ_TOP   = 2 * (ISQ_STEPS - 1);
    localparam int RW        = ISQ_STEPS;
    localparam int FRAC      = UNIT_W - 2;
    localparam int NUMW      = NW + FRAC + 1;
    localparam int QW        = UNIT_W;
    localparam int DIV_STEPS = QW;
    localparam int DVW       = RW + QW;
    localparam logic [LW-1:0] TOP_POS = LW'(NW - 1);
    localparam logic [QW-1:0] Q_MAX   = {1'b0, {(QW-1){1'b1}}};

    typedef struct packed {
        logic [2:0][NW-1:0] mag;
        logic [2:0]         neg;
        logic               zero;
        logic               deg;
    } t_carry;

    function automatic logic [LW-1:0] f_lead(input logic [MW-1:0] v);
        logic [LW-1:0] p;
        p = '0;
        for (int k = 0; k < MW; k++) begin
            if (v[k]) p = LW'(k);
        end
        return p;
    endfunction

    // stage 1: magnitudes and largest magnitude
    logic [2:0][MW-1:0] w_mag;
    logic [MW-1:0]      w_max;
    logic [2:0][MW-1:0] r1_mag;
    logic [MW-1:0]      r1_max;
    logic [2:0]         r1_neg;
    logic               r1_deg, r1_vld;
    logic [SW-1:0]      r1_side;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_mag[i] = i_vec[i][MW-1] ? (~i_vec[i] + MW'(1)) : i_vec[i];
        end
        w_max = w_mag[0];
        if (w_mag[1] > w_max) w_max = w_mag[1];
        if (w_mag[2] > w_max) w_max = w_mag[2];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_mag  <= w_mag;
            r1_max  <= w_max;
            for (int i = 0; i < 3; i++) r1_neg[i] <= i_vec[i][MW-1];
            r1_deg  <= i_deg;
            r1_side <= i_side;
        end
    end

    // stage 2: leading one of the largest magnitude
    logic [2:0][MW-1:0] r2_mag;
    logic [LW-1:0]      r2_lead;
    logic [2:0]         r2_neg;
    logic               r2_zero, r2_deg, r2_vld;
    logic [SW-1:0]      r2_side;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_mag  <= r1_mag;
            r2_lead <= f_lead(r1_max);
            r2_neg  <= r1_neg;
            r2_zero <= (r1_max == '0);
            r2_deg  <= r1_deg;
            r2_side <= r1_side;
        end
    end

    // stage 3: shift so the largest magnitude has its top bit at NW-1
    logic [2:0][NW-1:0] w_sh;
    t_carry             r3_c;
    logic [SW-1:0]      r3_side;
    logic               r3_vld;

    always_comb begin
        logic [MW-1:0] t;
        for (int i = 0; i < 3; i++) begin
            t = (r2_lead > TOP_POS) ? (r2_mag[i] >> (r2_lead - TOP_POS))
                                    : (r2_mag[i] << (TOP_POS - r2_lead));
            w_sh[i] = t[NW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_c.mag  <= w_sh;
            r3_c.neg  <= r2_neg;
            r3_c.zero <= r2_zero;
            r3_c.deg  <= r2_deg;
            r3_side   <= r2_side;
        end
    end

    // stage 4: squares
    logic [2:0][SQW-1:0] r4_sq;
    t_carry              r4_c;
    logic [SW-1:0]       r4_side;
    logic                r4_vld;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) r4_sq[i] <= r3_c.mag[i] * r3_c.mag[i];
            r4_c    <= r3_c;
            r4_side <= r3_side;
        end
    end

    // square root: index 0 holds the sum of squares
    logic [RTW-1:0] r_in  [0:ISQ_STEPS];
    logic [RTW-1:0] r_ir  [0:ISQ_STEPS];
    t_carry         r_ic  [0:ISQ_STEPS];
    logic [SW-1:0]  r_is  [0:ISQ_STEPS];
    logic           r_iv  [0:ISQ_STEPS];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_in[0] <= RTW'(r4_sq[0]) + RTW'(r4_sq[1]) + RTW'(r4_sq[2]);
            r_ir[0] <= '0;
            r_ic[0] <= r4_c;
            r_is[0] <= r4_side;
        end
    end

    for (genvar k = 0; k < ISQ_STEPS; k++) begin : g_isq
        localparam logic [RTW-1:0] BIT = RTW'(1) << (ISQ_TOP - 2 * k);
        logic [RTW-1:0] w_t, n_n, n_r;
        always_comb begin
            w_t = r_ir[k] + BIT;
            if (r_in[k] >= w_t) begin
                n_n = r_in[k] - w_t;
                n_r = (r_ir[k] >> 1) + BIT;
            end else begin
                n_n = r_in[k];
                n_r = r_ir[k] >> 1;
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_in[k+1] <= n_n;
                r_ir[k+1] <= n_r;
                r_ic[k+1] <= r_ic[k];
                r_is[k+1] <= r_is[k];
            end
        end
    end

    // division: index 0 holds the rounded numerators
    logic [2:0][NUMW-1:0] r_dr [0:DIV_STEPS];
    logic [2:0][QW-1:0]   r_dq [0:DIV_STEPS];
    logic [RW-1:0]        r_dd [0:DIV_STEPS];
    t_carry               r_dc [0:DIV_STEPS];
    logic [SW-1:0]        r_ds [0:DIV_STEPS];
    logic                 r_dv [0:DIV_STEPS];
    logic [RW-1:0]        w_root;

    assign w_root = r_ir[ISQ_STEPS][RW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_dr[0][i] <= NUMW'({r_ic[ISQ_STEPS].mag[i], {FRAC{1'b0}}})
                              + NUMW'(w_root >> 1);
            end
            r_dq[0] <= '0;
            r_dd[0] <= w_root;
            r_dc[0] <= r_ic[ISQ_STEPS];
            r_ds[0] <= r_is[ISQ_STEPS];
        end
    end

    for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
        localparam int B = DIV_STEPS - 1 - j;
        logic [DVW-1:0]       w_d;
        logic [2:0][NUMW-1:0] n_r;
        logic [2:0][QW-1:0]   n_q;
        always_comb begin
            w_d = DVW'(r_dd[j]) << B;
            n_r = r_dr[j];
            n_q = r_dq[j];
            for (int i = 0; i < 3; i++) begin
                if (DVW'(r_dr[j][i]) >= w_d) begin
                    n_r[i]    = r_dr[j][i] - w_d[NUMW-1:0];
                    n_q[i][B] = 1'b1;
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dr[j+1] <= n_r;
                r_dq[j+1] <= n_q;
                r_dd[j+1] <= r_dd[j];
                r_dc[j+1] <= r_dc[j];
                r_ds[j+1] <= r_ds[j];
            end
        end
    end

    // final stage: saturate, sign, zero vector
    t_uvec w_unit;
    always_comb begin
        logic [QW-1:0] q;
        for (int i = 0; i < 3; i++) begin
            q = (r_dq[DIV_STEPS][i] > Q_MAX) ? Q_MAX : r_dq[DIV_STEPS][i];
            if (r_dc[DIV_STEPS].zero) w_unit[i] = '0;
            else if (r_dc[DIV_STEPS].neg[i]) w_unit[i] = ~q + QW'(1);
            else w_unit[i] = q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_unit <= w_unit;
            o_deg  <= r_dc[DIV_STEPS].deg | r_dc[DIV_STEPS].zero;
            o_side <= r_ds[DIV_STEPS];
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
            for (int k = 0; k <= ISQ_STEPS; k++) r_iv[k] <= 1'b0;
            for (int j = 0; j <= DIV_STEPS; j++) r_dv[j] <= 1'b0;
            o_vld  <= 1'b0;
        end else if (i_en) begin
            r1_vld  <= i_vld;
            r2_vld  <= r1_vld;
            r3_vld  <= r2_vld;
            r4_vld  <= r3_vld;
            r_iv[0] <= r4_vld;
            for (int k = 0; k < ISQ_STEPS; k++) r_iv[k+1] <= r_iv[k];
            r_dv[0] <= r_iv[ISQ_STEPS];
            for (int j = 0; j < DIV_STEPS; j++) r_dv[j+1] <= r_dv[j];
            o_vld   <= r_dv[DIV_STEPS];
        end
    end

endmodule

@@ rtl/look_at_rotation_basis.sv @@
// Top level of the look-at rotation basis block: direction, cross products
// and four normalizers, with an output skid register. Depends on lab_pkg, lab_norm.
//
//   channel   valid          ready          payload
//   request   i_req_valid    o_req_ready    i_req  (lab_pkg::t_req)
//   result    o_res_valid    i_res_ready    o_res  (lab_pkg::t_res)
//
// One request per cycle while the skid register is empty; the path runs through
// three 54-stage normalizers in series, mostly square-root and divider stages,
// plus the difference and cross-product stages r_a, r_b1, r_b2, r_c1 and r_c2.
// Reset clears only the valid bits, the skid register's valid flag among them.
// A stalled result parks in the skid register; the pipeline then freezes
// and o_req_ready drops until the parked result is taken.
`include "look_at_rotation_basis_macros.svh"

module look_at_rotation_basis (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    output logic           o_req_ready,
    input  lab_pkg::t_req  i_req,
    output logic           o_res_valid,
    input  logic           i_res_ready,
    output lab_pkg::t_res  o_res
);
    import lab_pkg::*;

    localparam int PW = 2 * UNIT_W;

    logic w_en;
    logic r_skid_vld;
    t_res r_skid;
    t_res w_last;

    assign w_en        = ~r_skid_vld;
    assign o_req_ready = w_en;

    // direction and up vector at full width
    logic  r_a_vld;
    t_wvec r_a_d, r_a_up;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_d[0]  <= {i_req.look_x[IN_W-1], i_req.look_x}
                         - {i_req.pos_x[IN_W-1], i_req.pos_x};
            r_a_d[1]  <= {i_req.look_y[IN_W-1], i_req.look_y}
                         - {i_req.pos_y[IN_W-1], i_req.pos_y};
            r_a_d[2]  <= {i_req.look_z[IN_W-1], i_req.look_z}
                         - {i_req.pos_z[IN_W-1], i_req.pos_z};
            r_a_up[0] <= {i_req.up_x[IN_W-1], i_req.up_x};
            r_a_up[1] <= {i_req.up_y[IN_W-1], i_req.up_y};
            r_a_up[2] <= {i_req.up_z[IN_W-1], i_req.up_z};
        end
    end

    logic       w_d_vld, w_y_vld, w_d_deg, w_y_deg;
    logic [0:0] w_d_side, w_y_side;
    t_uvec      w_dn, w_yn;

    lab_norm #(.SW(1)) u_norm_d (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_vld(r_a_vld),
        .i_vec(r_a_d), .i_deg(1'b0), .i_side(1'b0),
        .o_vld(w_d_vld), .o_unit(w_dn), .o_deg(w_d_deg), .o_side(w_d_side)
    );

    lab_norm #(.SW(1)) u_norm_y (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_vld(r_a_vld),
        .i_vec(r_a_up), .i_deg(1'b0), .i_side(1'b0),
        .o_vld(w_y_vld), .o_unit(w_yn), .o_deg(w_y_deg), .o_side(w_y_side)
    );

    // X = Y x D: products, then differences
    logic                 r_b1_vld, r_b1_deg;
    logic [5:0][PW-1:0]   r_b1_p;
    t_uvec                r_b1_y;
    logic                 r_b2_vld, r_b2_deg;
    t_wvec                r_b2_x;
    t_uvec                r_b2_y;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_b1_p[0] <= PW'($signed(w_yn[1]) * $signed(w_dn[2]));
            r_b1_p[1] <= PW'($signed(w_yn[2]) * $signed(w_dn[1]));
            r_b1_p[2] <= PW'($signed(w_yn[2]) * $signed(w_dn[0]));
            r_b1_p[3] <= PW'($signed(w_yn[0]) * $signed(w_dn[2]));
            r_b1_p[4] <= PW'($signed(w_yn[0]) * $signed(w_dn[1]));
            r_b1_p[5] <= PW'($signed(w_yn[1]) * $signed(w_dn[0]));
            r_b1_y    <= w_yn;
            r_b1_deg  <= w_d_deg | w_y_deg | w_d_side[0] | w_y_side[0];
            for (int i = 0; i < 3; i++) begin
                r_b2_x[i] <= {r_b1_p[2*i][PW-1], r_b1_p[2*i]}
                             - {r_b1_p[2*i+1][PW-1], r_b1_p[2*i+1]};
            end
            r_b2_y    <= r_b1_y;
            r_b2_deg  <= r_b1_deg;
        end
    end

    logic             w_x_vld, w_x_deg;
    t_uvec            w_xn;
    logic [3*UNIT_W-1:0] w_x_side;

    lab_norm #(.SW(3*UNIT_W)) u_norm_x (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_vld(r_b2_vld),
        .i_vec(r_b2_x), .i_deg(r_b2_deg), .i_side(r_b2_y),
        .o_vld(w_x_vld), .o_unit(w_xn), .o_deg(w_x_deg), .o_side(w_x_side)
    );

    // Z = X x Y
    t_uvec              w_xy;
    logic               r_c1_vld, r_c1_deg;
    logic [5:0][PW-1:0] r_c1_p;
    t_uvec              r_c1_x, r_c1_y;
    logic               r_c2_vld, r_c2_deg;
    t_wvec              r_c2_z;
    t_uvec              r_c2_x, r_c2_y;

    assign w_xy = w_x_side;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c1_p[0] <= PW'($signed(w_xn[1]) * $signed(w_xy[2]));
            r_c1_p[1] <= PW'($signed(w_xn[2]) * $signed(w_xy[1]));
            r_c1_p[2] <= PW'($signed(w_xn[2]) * $signed(w_xy[0]));
            r_c1_p[3] <= PW'($signed(w_xn[0]) * $signed(w_xy[2]));
            r_c1_p[4] <= PW'($signed(w_xn[0]) * $signed(w_xy[1]));
            r_c1_p[5] <= PW'($signed(w_xn[1]) * $signed(w_xy[0]));
            r_c1_x    <= w_xn;
            r_c1_y    <= w_xy;
            r_c1_deg  <= w_x_deg;
            for (int i = 0; i < 3; i++) begin
                r_c2_z[i] <= {r_c1_p[2*i][PW-1], r_c1_p[2*i]}
                             - {r_c1_p[2*i+1][PW-1], r_c1_p[2*i+1]};
            end
            r_c2_x    <= r_c1_x;
            r_c2_y    <= r_c1_y;
            r_c2_deg  <= r_c1_deg;
        end
    end

    logic                w_z_vld, w_z_deg;
    t_uvec               w_zn;
    logic [6*UNIT_W-1:0] w_z_side;
    t_uvec               w_fx, w_fy;

    lab_norm #(.SW(6*UNIT_W)) u_norm_z (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_vld(r_c2_vld),
        .i_vec(r_c2_z), .i_deg(r_c2_deg), .i_side({r_c2_x, r_c2_y}),
        .o_vld(w_z_vld), .o_unit(w_zn), .o_deg(w_z_deg), .o_side(w_z_side)
    );

    assign w_fx = w_z_side[6*UNIT_W-1:3*UNIT_W];
    assign w_fy = w_z_side[3*UNIT_W-1:0];

    always_comb begin
        w_last.right_x    = w_fx[0];
        w_last.right_y    = w_fx[1];
        w_last.right_z    = w_fx[2];
        w_last.upaxis_x   = w_fy[0];
        w_last.upaxis_y   = w_fy[1];
        w_last.upaxis_z   = w_fy[2];
        w_last.fwd_x      = w_zn[0];
        w_last.fwd_y      = w_zn[1];
        w_last.fwd_z      = w_zn[2];
        w_last.degenerate = w_z_deg;
    end

    // valid bits of the top-level stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld  <= 1'b0;
            r_b1_vld <= 1'b0;
            r_b2_vld <= 1'b0;
            r_c1_vld <= 1'b0;
            r_c2_vld <= 1'b0;
        end else if (w_en) begin
            r_a_vld  <= i_req_valid;
            r_b1_vld <= w_d_vld;
            r_b2_vld <= r_b1_vld;
            r_c1_vld <= w_x_vld;
            r_c2_vld <= r_c1_vld;
        end
    end

    // skid: park a result that is not taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (i_res_ready) r_skid_vld <= 1'b0;
        end else if (w_z_vld && !i_res_ready) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_skid_vld) r_skid <= w_last;
    end

    assign o_res_valid = r_skid_vld | w_z_vld;
    assign o_res       = r_skid_vld ? r_skid : w_last;

    `LAB_ASSERT_NOW(a_dy_align, i_clk, i_rst_n, 1'b1, w_d_vld == w_y_vld)
    `LAB_ASSERT_NEXT(a_skid_hold, i_clk, i_rst_n, r_skid_vld && !i_res_ready, r_skid_vld && $stable(r_skid))
    `LAB_ASSERT_NOW(a_up_nonzero, i_clk, i_rst_n, o_res_valid && !o_res.degenerate, (o_res.upaxis_x != 0) || (o_res.upaxis_y != 0) || (o_res.upaxis_z != 0))

endmodule
